[hw/rtl/odpm_pkg.sv]
// ----------------------------------------------------------------------------
// odpm_pkg
// Shared types, constants and helpers for the ordered dither palette mapper.
// ----------------------------------------------------------------------------
package odpm_pkg;

  localparam int MapChannelBitsDefault = 5;
  localparam int ChanW = 8;
  localparam int PalChanW = 6;
  localparam int DistW = 20;     // 9 * 255^2 < 2^20
  localparam int KW = 6;         // dither ratio 0..63
  localparam int IdxW = 8;

  typedef enum logic [1:0] {
    OP_PIXEL = 2'd0,
    OP_MAP_WR = 2'd1,
    OP_PAL_WR = 2'd2,
    OP_NONE = 2'd3
  } opcode_t;

  localparam logic REG_OFFSET_X = 1'b0;
  localparam logic REG_OFFSET_Y = 1'b1;

  localparam logic [KW-1:0] K_MAX = 6'd63;

  typedef logic [3*ChanW-1:0] rgb_t;

  // 8x8 threshold pattern, indexed {row, col}
  localparam logic [5:0] BAYER [64] = '{
    6'd0,  6'd32, 6'd8,  6'd40, 6'd2,  6'd34, 6'd10, 6'd42,
    6'd48, 6'd16, 6'd56, 6'd24, 6'd50, 6'd18, 6'd58, 6'd26,
    6'd12, 6'd44, 6'd4,  6'd36, 6'd14, 6'd46, 6'd6,  6'd38,
    6'd60, 6'd28, 6'd52, 6'd20, 6'd62, 6'd30, 6'd54, 6'd22,
    6'd3,  6'd35, 6'd11, 6'd43, 6'd1,  6'd33, 6'd9,  6'd41,
    6'd51, 6'd19, 6'd59, 6'd27, 6'd49, 6'd17, 6'd57, 6'd25,
    6'd15, 6'd47, 6'd7,  6'd39, 6'd13, 6'd45, 6'd5,  6'd37,
    6'd63, 6'd31, 6'd55, 6'd23, 6'd61, 6'd29, 6'd53, 6'd21
  };

  // round(v*255/63): divide by 63 as multiply by 2^20/63 rounded up
  function automatic logic [ChanW-1:0] scale6(input logic [PalChanW-1:0] v);
    logic [13:0] x;
    logic [27:0] p;
    x = 14'({8'd0, v} * 14'd255 + 14'd31);
    p = 28'(x * 28'd16645);
    return p[27:20];
  endfunction

  // palette entry {r6,g6,b6} to scaled 8-bit rgb
  function automatic rgb_t pal_scale(input logic [3*PalChanW-1:0] e);
    return {scale6(e[17:12]), scale6(e[11:6]), scale6(e[5:0])};
  endfunction

endpackage

[hw/rtl/odpm_dist.sv]
// ----------------------------------------------------------------------------
// odpm_dist
// Weighted colour distance 3*dr^2 + 4*dg^2 + 2*db^2, two register stages.
// ----------------------------------------------------------------------------
module odpm_dist (
  input  logic                  clk,
  input  logic                  en,
  input  odpm_pkg::rgb_t        col_a,
  input  odpm_pkg::rgb_t        col_b,
  output logic [odpm_pkg::DistW-1:0] wsum
);
  import odpm_pkg::*;

  logic [ChanW-1:0] ad [3];
  logic [2*ChanW-1:0] sq [3];

  // absolute channel differences
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (col_a[i*ChanW +: ChanW] >= col_b[i*ChanW +: ChanW]) begin
        ad[i] = col_a[i*ChanW +: ChanW] - col_b[i*ChanW +: ChanW];
      end else begin
        ad[i] = col_b[i*ChanW +: ChanW] - col_a[i*ChanW +: ChanW];
      end
    end
  end

  // stage 1: squares; stage 2: weighted sum (index 2 red, 1 green, 0 blue)
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq[i] <= {8'd0, ad[i]} * {8'd0, ad[i]};
      end
      wsum <= DistW'(3 * {4'd0, sq[2]}) + DistW'({4'd0, sq[1]} << 2)
            + DistW'({4'd0, sq[0]} << 1);
    end
  end

endmodule

[hw/rtl/odpm_div.sv]
// ----------------------------------------------------------------------------
// odpm_div
// Pipelined restoring divider: k = min(63, 64*num/den), one bit per stage.
// ----------------------------------------------------------------------------
module odpm_div #(
  parameter int SIDE_W = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_vld,
  input  logic [odpm_pkg::DistW-1:0] num,
  input  logic [odpm_pkg::DistW-1:0] den,
  input  logic [SIDE_W-1:0]          side_in,
  output logic                       out_vld,
  output logic [odpm_pkg::KW-1:0]    k,
  output logic [SIDE_W-1:0]          side_out,
  output logic                       busy
);
  import odpm_pkg::*;

  localparam int NStg = KW + 1;

  logic [NStg-1:0] vld;
  logic [DistW-1:0] rem [NStg];
  logic [DistW-1:0] dv [NStg];
  logic [KW-1:0] quo [NStg];
  logic [NStg-1:0] sat;
  logic [SIDE_W-1:0] side [NStg];

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NStg-2:0], in_vld};
    end
  end

  // entry stage: ratio of 64 or more saturates
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num;
      dv[0] <= den;
      quo[0] <= '0;
      sat[0] <= (num >= den);
      side[0] <= side_in;
    end
  end

  // one quotient bit per stage
  for (genvar s = 0; s < KW; s++) begin : g_stg
    logic [DistW:0] r2;
    assign r2 = {rem[s], 1'b0};
    always_ff @(posedge clk) begin
      if (en) begin
        if (r2 >= {1'b0, dv[s]}) begin
          rem[s+1] <= DistW'(r2 - {1'b0, dv[s]});
          quo[s+1] <= {quo[s][KW-2:0], 1'b1};
        end else begin
          rem[s+1] <= r2[DistW-1:0];
          quo[s+1] <= {quo[s][KW-2:0], 1'b0};
        end
        dv[s+1] <= dv[s];
        sat[s+1] <= sat[s];
        side[s+1] <= side[s];
      end
    end
  end

  assign out_vld = vld[NStg-1];
  assign k = sat[NStg-1] ? K_MAX : quo[NStg-1];
  assign side_out = side[NStg-1];
  assign busy = |vld;

endmodule

[hw/rtl/ordered_dither_palette_mapper_core.sv]
// ----------------------------------------------------------------------------
// ordered_dither_palette_mapper_core
// RGBA to palette index with 8x8 ordered dither between nearest and opposite.
// ----------------------------------------------------------------------------
// channel   direction  handshake            payload
// in        input      in_valid/in_ready    opcode, rgba, x/y, entry fields
// out       output     out_valid/out_ready  color_index
// cfg       input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One pixel per cycle while out is not stalled; a pixel passes through 8 lookup
// and distance stages, the first loaded at the accepting edge, 7 divider
// stages and the output register before out_valid rises.
// Table writes are taken only once the pipeline holds no pixel, and apply
// at the accepting edge. Opcode 3 is likewise taken once empty and dropped.
// A stall on out stalls the whole pipeline; rst clears all valid bits and
// offsets. Colour map and palette contents are undefined until written.
// ----------------------------------------------------------------------------
module ordered_dither_palette_mapper_core #(
  parameter int MAP_CHANNEL_BITS = odpm_pkg::MapChannelBitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic [7:0]  alpha,
  input  logic [15:0] x_pos,
  input  logic [15:0] y_pos,
  input  logic [14:0] entry_address,
  input  logic [7:0]  entry_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  color_index,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [2:0]  cfg_data
);
  import odpm_pkg::*;

  localparam int B = MAP_CHANNEL_BITS;
  localparam int MapAW = 3 * B;
  localparam int MapDepth = 1 << MapAW;
  localparam int SideW = 2 + 2 * IdxW + KW;

  // stores
  logic [IdxW-1:0] color_map [MapDepth];
  logic [3*PalChanW-1:0] palette_store [256];

  logic [2:0] offset_x, offset_y;
  logic adv, in_acc, pipe_empty, div_busy;

  // stage registers a..h
  logic va, vb, vc, vd, ve, vf, vg, vh;
  rgb_t rgb_a, rgb_b, rgb_c;
  rgb_t n_c, n_d, n_e, n_f;
  rgb_t o_f;
  logic az_a, az_b, az_c, az_d, az_e, az_f, az_g, az_h;
  logic [KW-1:0] th_a, th_b, th_c, th_d, th_e, th_f, th_g, th_h;
  logic [IdxW-1:0] i1_a, i1_b, i1_c, i1_d, i1_e, i1_f, i1_g, i1_h;
  logic [IdxW-1:0] i2_d, i2_e, i2_f, i2_g, i2_h;
  logic [3*PalChanW-1:0] pe1_b, pe2_e;
  logic [DistW-1:0] d1_e, d1_f, d1_g, d1_h, spread_h;

  logic [MapAW-1:0] addr1, addr2, waddr;
  logic [MapAW+14:0] waddr_ext;
  logic [10:0] t [3];
  logic [ChanW-1:0] opp [3];
  logic [2:0] brow, bcol;

  logic dv_out;
  logic [KW-1:0] dk;
  logic [SideW-1:0] side_h, side_o;
  logic keep_h;
  logic [IdxW-1:0] pick;

  // handshake control
  assign adv = !out_valid || out_ready;
  assign pipe_empty = !(va || vb || vc || vd || ve || vf || vg || vh || div_busy
                        || out_valid);
  assign in_ready = adv && ((opcode == OP_PIXEL) || pipe_empty);
  assign in_acc = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x <= '0;
      offset_y <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_OFFSET_X) begin
        offset_x <= cfg_data;
      end else begin
        offset_y <= cfg_data;
      end
    end
  end

  // address forming
  assign addr1 = {red[7 -: B], green[7 -: B], blue[7 -: B]};
  assign waddr_ext = {{MapAW{1'b0}}, entry_address};
  assign waddr = waddr_ext[MapAW-1:0];
  assign brow = 3'(x_pos[2:0] + offset_x);
  assign bcol = 3'(y_pos[2:0] + offset_y);

  // table writes
  always_ff @(posedge clk) begin
    if (in_acc && (opcode == OP_MAP_WR)) begin
      color_map[waddr] <= entry_index;
    end
    if (in_acc && (opcode == OP_PAL_WR)) begin
      palette_store[entry_address[7:0]] <= {red[5:0], green[5:0], blue[5:0]};
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      {va, vb, vc, vd, ve, vf, vg, vh} <= '0;
    end else if (adv) begin
      va <= in_acc && (opcode == OP_PIXEL);
      vb <= va;
      vc <= vb;
      vd <= vc;
      ve <= vd;
      vf <= ve;
      vg <= vf;
      vh <= vg;
    end
  end

  // opposite colour: clamp(2*p - n) per channel
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t[i] = 11'({2'b0, rgb_c[i*ChanW +: ChanW], 1'b0}) - 11'({3'b0, n_c[i*ChanW +: ChanW]});
      if (t[i][10]) begin
        opp[i] = '0;
      end else if (t[i][9:8] != 2'b00) begin
        opp[i] = 8'd255;
      end else begin
        opp[i] = t[i][7:0];
      end
    end
  end
  assign addr2 = {opp[2][7 -: B], opp[1][7 -: B], opp[0][7 -: B]};

  // lookup pipeline
  always_ff @(posedge clk) begin
    if (adv) begin
      // a: nearest index
      i1_a <= color_map[addr1];
      rgb_a <= {red, green, blue};
      az_a <= (alpha == 8'd0);
      th_a <= BAYER[{brow, bcol}];
      // b: nearest palette entry
      pe1_b <= palette_store[i1_a];
      rgb_b <= rgb_a; az_b <= az_a; th_b <= th_a; i1_b <= i1_a;
      // c: scale nearest
      n_c <= pal_scale(pe1_b);
      rgb_c <= rgb_b; az_c <= az_b; th_c <= th_b; i1_c <= i1_b;
      // d: opposite index
      i2_d <= color_map[addr2];
      n_d <= n_c; az_d <= az_c; th_d <= th_c; i1_d <= i1_c;
      // e: opposite palette entry
      pe2_e <= palette_store[i2_d];
      n_e <= n_d; az_e <= az_d; th_e <= th_d; i1_e <= i1_d; i2_e <= i2_d;
      // f: scale opposite
      o_f <= pal_scale(pe2_e);
      n_f <= n_e; az_f <= az_e; th_f <= th_e; i1_f <= i1_e; i2_f <= i2_e;
      d1_f <= d1_e;
      // g, h: spread distance in flight
      az_g <= az_f; th_g <= th_f; i1_g <= i1_f; i2_g <= i2_f; d1_g <= d1_f;
      az_h <= az_g; th_h <= th_g; i1_h <= i1_g; i2_h <= i2_g; d1_h <= d1_g;
    end
  end

  // dist(pixel, nearest): c -> e
  odpm_dist u_dist_pn (
    .clk   (clk),
    .en    (adv),
    .col_a (rgb_c),
    .col_b (n_c),
    .wsum  (d1_e)
  );

  // dist(nearest, opposite): f -> h
  odpm_dist u_dist_no (
    .clk   (clk),
    .en    (adv),
    .col_a (n_f),
    .col_b (o_f),
    .wsum  (spread_h)
  );

  // keep nearest when indices match or spread is zero
  assign keep_h = (i1_h == i2_h) || (spread_h == '0);
  assign side_h = {az_h, keep_h, i1_h, i2_h, th_h};

  odpm_div #(
    .SIDE_W (SideW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_vld   (vh),
    .num      (d1_h),
    .den      (spread_h),
    .side_in  (side_h),
    .out_vld  (dv_out),
    .k        (dk),
    .side_out (side_o),
    .busy     (div_busy)
  );

  // final choice: fields {az, keep, i1, i2, th}
  always_comb begin
    if (side_o[SideW-1]) begin
      pick = '0;
    end else if (side_o[SideW-2] || (side_o[KW-1:0] >= dk)) begin
      pick = side_o[KW+2*IdxW-1 -: IdxW];
    end else begin
      pick = side_o[KW+IdxW-1 -: IdxW];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_out;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      color_index <= pick;
    end
  end

`ifndef SYNTHESIS
  // table writes only land in an empty pipeline
  a_wr_empty: assert property (@(posedge clk) disable iff (rst)
    (in_acc && (opcode != OP_PIXEL)) |-> pipe_empty)
    else $error("table write accepted with pixels in flight");

  // an accepted pixel enters stage a
  a_pix_enter: assert property (@(posedge clk) disable iff (rst)
    (in_acc && (opcode == OP_PIXEL)) |=> va)
    else $error("accepted pixel lost at entry");

  // a stall freezes the stage valid bits
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable({va, vb, vc, vd, ve, vf, vg, vh}))
    else $error("pipeline moved during stall");

  // nothing accepted while the output stalls
  a_no_acc_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input accepted during output stall");
`endif

endmodule
